/* hdl/s4i_pkg.sv */
`default_nettype none
// ============================================================================
// s4i_pkg
// Shared types, constants and index tables for the symmetric 4x4 inverse
// and determinant pipeline.
// ============================================================================
package s4i_pkg;

    localparam int DATA_WIDTH  = 64;
    localparam int FRAC_BITS   = 32;
    localparam int FIELD_W     = 64;
    localparam int MUL_DIGIT   = 32;
    localparam int N_ELEM      = 10;
    localparam int N_MINOR     = 12;
    localparam int N_COF       = 10;
    localparam int N_TERM      = 3;
    localparam int N_DET_TERM  = 4;

    typedef struct packed {
        logic signed [FIELD_W-1:0] m00;
        logic signed [FIELD_W-1:0] m01;
        logic signed [FIELD_W-1:0] m02;
        logic signed [FIELD_W-1:0] m03;
        logic signed [FIELD_W-1:0] m11;
        logic signed [FIELD_W-1:0] m12;
        logic signed [FIELD_W-1:0] m13;
        logic signed [FIELD_W-1:0] m22;
        logic signed [FIELD_W-1:0] m23;
        logic signed [FIELD_W-1:0] m33;
    } s4i_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] determinant;
        logic signed [FIELD_W-1:0] i00;
        logic signed [FIELD_W-1:0] i01;
        logic signed [FIELD_W-1:0] i02;
        logic signed [FIELD_W-1:0] i03;
        logic signed [FIELD_W-1:0] i11;
        logic signed [FIELD_W-1:0] i12;
        logic signed [FIELD_W-1:0] i13;
        logic signed [FIELD_W-1:0] i22;
        logic signed [FIELD_W-1:0] i23;
        logic signed [FIELD_W-1:0] i33;
        logic                      singular;
    } s4i_out_t;

    // Element order: m00 m01 m02 m03 m11 m12 m13 m22 m23 m33.
    // Each 2x2 minor is e[a]*e[b] - e[c]*e[d]; rows 0-1 first, then rows 2-3.
    localparam int MINOR_IDX [N_MINOR][4] = '{
        '{0, 4, 1, 1}, '{0, 5, 1, 2}, '{0, 6, 1, 3},
        '{1, 5, 4, 2}, '{1, 6, 4, 3}, '{2, 6, 5, 3},
        '{2, 6, 3, 5}, '{2, 8, 3, 7}, '{2, 9, 3, 8},
        '{5, 8, 6, 7}, '{5, 9, 6, 8}, '{7, 9, 8, 8}
    };

    // Adjugate terms: element index, minor index, negate flag.
    localparam int COF_TERM [N_COF*N_TERM][3] = '{
        '{4, 11, 0}, '{5, 10, 1}, '{6, 9, 0},
        '{1, 11, 1}, '{2, 10, 0}, '{3, 9, 1},
        '{6, 5, 0},  '{8, 4, 1},  '{9, 3, 0},
        '{5, 5, 1},  '{7, 4, 0},  '{8, 3, 1},
        '{0, 11, 0}, '{2, 8, 1},  '{3, 7, 0},
        '{3, 5, 1},  '{8, 2, 0},  '{9, 1, 1},
        '{2, 5, 0},  '{7, 2, 1},  '{8, 1, 0},
        '{3, 4, 0},  '{6, 2, 1},  '{9, 0, 0},
        '{2, 4, 1},  '{5, 2, 0},  '{8, 0, 1},
        '{2, 3, 0},  '{5, 1, 1},  '{7, 0, 0}
    };

endpackage
`default_nettype wire

/* hdl/s4i_mul.sv */
`default_nettype none
// ============================================================================
// s4i_mul
// Pipelined signed multiplier that accumulates one digit-by-digit partial
// product per register stage.
// ============================================================================
module s4i_mul #(
    parameter int AW = 64,
    parameter int BW = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [AW-1:0]  a,
    input  wire logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0]    p
);

    localparam int DG  = s4i_pkg::MUL_DIGIT;
    localparam int NDA = (AW + DG - 1) / DG;
    localparam int NDB = (BW + DG - 1) / DG;
    localparam int AXW = NDA * DG;
    localparam int BXW = NDB * DG;
    localparam int ACW = AXW + BXW + 2;
    localparam int NS  = NDA * NDB;

    logic signed [AW-1:0]  a_reg   [NS];
    logic signed [BW-1:0]  b_reg   [NS];
    logic signed [ACW-1:0] acc_reg [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int DI = s / NDB;
        localparam int DJ = s % NDB;
        logic signed [AW-1:0]    a_in;
        logic signed [BW-1:0]    b_in;
        logic signed [AXW-1:0]   ax;
        logic signed [BXW-1:0]   bx;
        logic signed [DG:0]      da;
        logic signed [DG:0]      db;
        logic signed [2*DG+1:0]  pr;
        logic signed [ACW-1:0]   term;
        logic signed [ACW-1:0]   acc_in;

        if (s == 0) begin : g_first
            assign a_in   = a;
            assign b_in   = b;
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = a_reg[s-1];
            assign b_in   = b_reg[s-1];
            assign acc_in = acc_reg[s-1];
        end

        always_comb begin
            ax   = AXW'(a_in);
            bx   = BXW'(b_in);
            da   = $signed({(DI == NDA - 1) ? ax[AXW-1] : 1'b0, ax[DI*DG +: DG]});
            db   = $signed({(DJ == NDB - 1) ? bx[BXW-1] : 1'b0, bx[DJ*DG +: DG]});
            pr   = da * db;
            term = ACW'(pr) <<< (DG * (DI + DJ));
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[s]   <= a_in;
                b_reg[s]   <= b_in;
                acc_reg[s] <= acc_in + term;
            end
        end
    end

    assign p = acc_reg[NS-1][AW+BW-1:0];

endmodule
`default_nettype wire

/* hdl/s4i_div.sv */
`default_nettype none
// ============================================================================
// s4i_div
// Pipelined restoring divider: one quotient bit per stage, truncation toward
// zero, result saturated to the signed output width.
// ============================================================================
module s4i_div #(
    parameter int N  = 64,
    parameter int NW = 193,
    parameter int DW = 258,
    parameter int F  = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [DW-1:0] den,
    output logic signed [N-1:0]       q
);

    localparam int RA = NW + 2 * F;
    localparam int RB = DW + N;
    localparam int RW = ((RA > RB) ? RA : RB) + 1;

    logic [NW-1:0] nm;
    logic [DW-1:0] dm;
    logic [RW-1:0] r0;

    logic [RW-1:0] r_reg   [N+1];
    logic [DW-1:0] d_reg   [N];
    logic [N-1:0]  q_reg   [N+1];
    logic          neg_reg [N+1];
    logic          ovf_reg [N+1];
    logic signed [N-1:0] q_out_reg;
    logic          big;

    always_comb begin
        nm = num[NW-1] ? NW'(-num) : NW'(num);
        dm = den[DW-1] ? DW'(-den) : DW'(den);
        r0 = RW'(nm) << (2 * F);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= r0;
            d_reg[0]   <= dm;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
            ovf_reg[0] <= r0 >= (RW'(dm) << N);
        end
    end

    for (genvar t = 0; t < N; t++) begin : g_bit
        logic [RW-1:0] sh;
        logic          ge;

        always_comb begin
            sh = RW'(d_reg[t]) << (N - 1 - t);
            ge = r_reg[t] >= sh;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[t+1]   <= ge ? r_reg[t] - sh : r_reg[t];
                q_reg[t+1]   <= q_reg[t] | (ge ? (N'(1) << (N - 1 - t)) : '0);
                neg_reg[t+1] <= neg_reg[t];
                ovf_reg[t+1] <= ovf_reg[t];
            end
        end

        if (t < N - 1) begin : g_den
            always_ff @(posedge aclk) begin
                if (en) begin
                    d_reg[t+1] <= d_reg[t];
                end
            end
        end
    end

    assign big = ovf_reg[N] || (q_reg[N] > {1'b1, {(N-1){1'b0}}});

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!neg_reg[N]) begin
                q_out_reg <= (ovf_reg[N] || q_reg[N][N-1]) ? $signed({1'b0, {(N-1){1'b1}}})
                                                           : $signed(q_reg[N]);
            end else begin
                q_out_reg <= big ? $signed({1'b1, {(N-1){1'b0}}}) : $signed(-q_reg[N]);
            end
        end
    end

    assign q = q_out_reg;

endmodule
`default_nettype wire

/* hdl/symmetric_4x4_inverse_det.sv */
`default_nettype none
// ============================================================================
// symmetric_4x4_inverse_det
// Determinant and inverse of a symmetric 4x4 fixed-point matrix.
// ============================================================================
// The block accepts one matrix transaction per clock cycle while s_ready is
// high (the skid stage is empty) and returns one result transaction per
// matrix, in order. L1, L2 and L3 are the stage counts of the three
// multiplier layers (digit count of the element times digit count of the
// other operand, in 32-bit digits). The pipeline length is set by the
// multiplier pipelines and by the restoring divider, which resolves one
// quotient bit per stage. The output register with a one-entry skid stage
// lets the pipeline keep accepting while one finished result waits.
// ============================================================================
module symmetric_4x4_inverse_det #(
    parameter int DATA_WIDTH = s4i_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = s4i_pkg::FRAC_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire s4i_pkg::s4i_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output s4i_pkg::s4i_out_t      m_data
);

    localparam int N   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DG  = s4i_pkg::MUL_DIGIT;
    localparam int NE  = s4i_pkg::N_ELEM;
    localparam int NM  = s4i_pkg::N_MINOR;
    localparam int NC  = s4i_pkg::N_COF;
    localparam int NT  = s4i_pkg::N_TERM;
    localparam int ND  = s4i_pkg::N_DET_TERM;
    localparam int FW  = s4i_pkg::FIELD_W;
    localparam int SW  = 2 * N + 1;
    localparam int CW  = 3 * N + 1;
    localparam int DW  = 4 * N + 2;
    localparam int NDN = (N + DG - 1) / DG;
    localparam int L1  = NDN * NDN;
    localparam int L2  = NDN * ((SW + DG - 1) / DG);
    localparam int L3  = NDN * ((CW + DG - 1) / DG);
    localparam int P2  = L1 + L2 + 2;
    localparam int P3  = P2 + L3 + 1;
    localparam int LD  = N + 2;
    localparam int LT  = P3 + LD + 1;

    logic en;
    logic v_reg [LT];

    logic signed [N-1:0]  ein   [NE];
    logic signed [N-1:0]  e_reg [NE];
    logic signed [N-1:0]  e1    [NE];
    logic signed [N-1:0]  e2    [ND];
    logic [NE*N-1:0]      ed1_reg [L1+1];
    logic [ND*N-1:0]      ed2_reg [P2];

    logic signed [2*N-1:0]  p1a [NM];
    logic signed [2*N-1:0]  p1b [NM];
    logic signed [SW-1:0]   minor_reg [NM];
    logic signed [N+SW-1:0] p2 [NC*NT];
    logic signed [CW-1:0]   cof_next [NC];
    logic signed [CW-1:0]   cof_reg  [NC];
    logic signed [N+CW-1:0] p3 [ND];
    logic signed [DW-1:0]   det_next;
    logic signed [DW-1:0]   det_reg;
    logic [NC*CW-1:0]       cd_reg [L3+1];
    logic signed [CW-1:0]   cof_d [NC];
    logic signed [N-1:0]    qv [NC];

    logic [DW-1:0]          dmag;
    logic [DW-1:0]          dsh;
    logic signed [N-1:0]    detq_next;
    logic [N:0]             dq_reg [LD];

    s4i_pkg::s4i_out_t pipe_data;
    s4i_pkg::s4i_out_t out_reg;
    s4i_pkg::s4i_out_t skid_reg;
    logic              out_v_reg;
    logic              skid_v_reg;
    logic              pipe_v;
    logic              sing;
    logic signed [N-1:0] detq;

    assign en      = !skid_v_reg;
    assign s_ready = en;

    // Input stage.
    always_comb begin
        ein[0] = s_data.m00[N-1:0];
        ein[1] = s_data.m01[N-1:0];
        ein[2] = s_data.m02[N-1:0];
        ein[3] = s_data.m03[N-1:0];
        ein[4] = s_data.m11[N-1:0];
        ein[5] = s_data.m12[N-1:0];
        ein[6] = s_data.m13[N-1:0];
        ein[7] = s_data.m22[N-1:0];
        ein[8] = s_data.m23[N-1:0];
        ein[9] = s_data.m33[N-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LT; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= s_valid;
            for (int k = 1; k < LT; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NE; k++) begin
                e_reg[k] <= ein[k];
            end
        end
    end

    // Element delay lines for the later multiplier layers.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NE; k++) begin
                ed1_reg[0][k*N +: N] <= e_reg[k];
            end
            for (int d = 1; d < L1 + 1; d++) begin
                ed1_reg[d] <= ed1_reg[d-1];
            end
            for (int k = 0; k < ND; k++) begin
                ed2_reg[0][k*N +: N] <= e_reg[k];
            end
            for (int d = 1; d < P2; d++) begin
                ed2_reg[d] <= ed2_reg[d-1];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            e1[k] = $signed(ed1_reg[L1][k*N +: N]);
        end
        for (int k = 0; k < ND; k++) begin
            e2[k] = $signed(ed2_reg[P2-1][k*N +: N]);
        end
    end

    // Layer 1: 2x2 minors.
    for (genvar k = 0; k < NM; k++) begin : g_minor
        s4i_mul #(.AW(N), .BW(N)) u_mul_a (
            .aclk (aclk),
            .en   (en),
            .a    (e_reg[s4i_pkg::MINOR_IDX[k][0]]),
            .b    (e_reg[s4i_pkg::MINOR_IDX[k][1]]),
            .p    (p1a[k])
        );
        s4i_mul #(.AW(N), .BW(N)) u_mul_b (
            .aclk (aclk),
            .en   (en),
            .a    (e_reg[s4i_pkg::MINOR_IDX[k][2]]),
            .b    (e_reg[s4i_pkg::MINOR_IDX[k][3]]),
            .p    (p1b[k])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                minor_reg[k] <= SW'(p1a[k]) - SW'(p1b[k]);
            end
        end
    end

    // Layer 2: adjugate entries.
    for (genvar k = 0; k < NC * NT; k++) begin : g_cterm
        s4i_mul #(.AW(N), .BW(SW)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (e1[s4i_pkg::COF_TERM[k][0]]),
            .b    (minor_reg[s4i_pkg::COF_TERM[k][1]]),
            .p    (p2[k])
        );
    end

    always_comb begin
        for (int j = 0; j < NC; j++) begin
            cof_next[j] = '0;
            for (int t = 0; t < NT; t++) begin
                if (s4i_pkg::COF_TERM[j*NT+t][2] != 0) begin
                    cof_next[j] = cof_next[j] - CW'(p2[j*NT+t]);
                end else begin
                    cof_next[j] = cof_next[j] + CW'(p2[j*NT+t]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NC; j++) begin
                cof_reg[j] <= cof_next[j];
            end
        end
    end

    // Layer 3: determinant along the first row.
    for (genvar j = 0; j < ND; j++) begin : g_dterm
        s4i_mul #(.AW(N), .BW(CW)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (e2[j]),
            .b    (cof_reg[j]),
            .p    (p3[j])
        );
    end

    always_comb begin
        det_next = '0;
        for (int j = 0; j < ND; j++) begin
            det_next = det_next + DW'(p3[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= det_next;
            for (int j = 0; j < NC; j++) begin
                cd_reg[0][j*CW +: CW] <= cof_reg[j];
            end
            for (int d = 1; d < L3 + 1; d++) begin
                cd_reg[d] <= cd_reg[d-1];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NC; j++) begin
            cof_d[j] = $signed(cd_reg[L3][j*CW +: CW]);
        end
    end

    // Layer 4: inverse entries.
    for (genvar j = 0; j < NC; j++) begin : g_div
        s4i_div #(.N(N), .NW(CW), .DW(DW), .F(F)) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (cof_d[j]),
            .den  (det_reg),
            .q    (qv[j])
        );
    end

    // Determinant scaling and saturation.
    always_comb begin
        dmag = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        dsh  = dmag >> (3 * F);
        if (!det_reg[DW-1]) begin
            detq_next = (dsh >= (DW'(1) << (N - 1))) ? $signed({1'b0, {(N-1){1'b1}}})
                                                      : $signed(dsh[N-1:0]);
        end else begin
            detq_next = (dsh > (DW'(1) << (N - 1))) ? $signed({1'b1, {(N-1){1'b0}}})
                                                     : $signed(-dsh[N-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dq_reg[0] <= {det_reg == '0, detq_next};
            for (int d = 1; d < LD; d++) begin
                dq_reg[d] <= dq_reg[d-1];
            end
        end
    end

    assign sing   = dq_reg[LD-1][N];
    assign detq   = $signed(dq_reg[LD-1][N-1:0]);
    assign pipe_v = v_reg[LT-1];

    always_comb begin
        pipe_data.singular    = sing;
        pipe_data.determinant = sing ? '0 : FW'(detq);
        pipe_data.i00         = sing ? '0 : FW'(qv[0]);
        pipe_data.i01         = sing ? '0 : FW'(qv[1]);
        pipe_data.i02         = sing ? '0 : FW'(qv[2]);
        pipe_data.i03         = sing ? '0 : FW'(qv[3]);
        pipe_data.i11         = sing ? '0 : FW'(qv[4]);
        pipe_data.i12         = sing ? '0 : FW'(qv[5]);
        pipe_data.i13         = sing ? '0 : FW'(qv[6]);
        pipe_data.i22         = sing ? '0 : FW'(qv[7]);
        pipe_data.i23         = sing ? '0 : FW'(qv[8]);
        pipe_data.i33         = sing ? '0 : FW'(qv[9]);
    end

    // Output register and skid stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_ready) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg  <= pipe_v;
            end
        end else if (pipe_v) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_ready) begin
            out_reg <= skid_v_reg ? skid_reg : pipe_data;
        end else if (en && pipe_v) begin
            skid_reg <= pipe_data;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    a_skid_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("Skid stage holds a transaction while the output is empty.");

    a_skid_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> !s_ready)
        else $error("Input accepted while the skid stage is full.");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_ready))
        else $error("Skid stage filled without an output stall.");

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.singular) |-> (m_data.determinant == '0 && m_data.i00 == '0
                                          && m_data.i33 == '0))
        else $error("Singular result carries nonzero outputs.");

endmodule
`default_nettype wire
